FILE: rtl/core/tpz_pkg.sv
// Shared types, constants and helpers of the torus point z-buffer plotter.
package tpz_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  localparam int DIV_STEPS = 29;  // quotient bits of 2^28 / den

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_PLOT  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_SIN_A  = 3'd0,
    CFG_COS_A  = 3'd1,
    CFG_SIN_B  = 3'd2,
    CFG_COS_B  = 3'd3,
    CFG_R1     = 3'd4,
    CFG_R2     = 3'd5,
    CFG_K2     = 3'd6,
    CFG_UNUSED = 3'd7
  } cfg_idx_e;

  // one shared multiply per step
  typedef enum logic [4:0] {
    MS_CPCT, MS_N1, MS_CACT, MS_N2, MS_N3, MS_CAST, MS_CTSA, MS_P5,
    MS_N4, MS_Q, MS_HS, MS_HC, MS_Z1, MS_RSA, MS_Z2, MS_T1,
    MS_RST, MS_T2, MS_X1, MS_X2, MS_Y1, MS_Y2, MS_XD, MS_YD
  } mstep_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_RD, ST_RDW, ST_MUL, ST_DEN, ST_DCHK,
    ST_DIV, ST_MULX, ST_MULY, ST_PROJ, ST_CHK, ST_LOOK, ST_CMP, ST_FIN
  } state_e;

  typedef struct packed {
    logic   load_in;
    logic   init_wr;
    logic   clr_cell;
    logic   rd_issue;
    logic   rd_take;
    logic   zero_res;
    logic   mul_en;
    mstep_e step;
    logic   den_en;
    logic   miss;
    logic   div_init;
    logic   div_en;
    logic   proj_en;
    logic   chk_en;
    logic   look_rd;
    logic   cmp_en;
    logic   out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic den_pos;
    logic on_scr;
    logic out_free;
  } dp_stat_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  function automatic logic [7:0] shade_char(input logic [3:0] lvl);
    logic [7:0] c;
    unique case (lvl)
      4'd0:    c = 8'h2E;  // .
      4'd1:    c = 8'h2C;  // ,
      4'd2:    c = 8'h2D;  // -
      4'd3:    c = 8'h7E;  // ~
      4'd4:    c = 8'h3A;  // :
      4'd5:    c = 8'h3B;  // ;
      4'd6:    c = 8'h3D;  // =
      4'd7:    c = 8'h21;  // !
      4'd8:    c = 8'h2A;  // *
      4'd9:    c = 8'h23;  // #
      4'd10:   c = 8'h24;  // $
      default: c = 8'h40;  // @
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/torus_point_zbuffer_plotter_top.sv
// Top level of the torus point z-buffer plotter: stream ports, config port, controller and datapath.
//
// Z-buffered plotter for one surface point of a spinning torus. Each input
// transaction carries a command in tuser (0 clear cell, 1 plot point, 2 read
// cell) and, in tdata, a cell index plus the Q1.14 sines and cosines of the
// ring and tube angles. A plot rotates the point by the configured angles,
// forms the inverse depth 1/(K2+z) with a bit-per-cycle divider, projects it to
// a text cell, runs the depth test and, if it wins, stores depth and shade
// character. Every command gives exactly one output transaction. A plot runs
// 22 steps of the single shared multiplier, 29 divider iterations, then the
// projection, again on the multiplier, and a read-modify-write of the cell
// memory; a clear blanks the cell, a read fetches it and code 3 returns zero.
// One command is in work at a time; a new one is taken while the previous
// result still waits in the output register. After reset a clearing pass over
// all SCREEN_COLS*SCREEN_ROWS cells (2000 by default) fills the cell memory
// with depth 0 and spaces; tready stays low until it ends. Config writes are
// always taken and must only be issued while the block is idle.
module torus_point_zbuffer_plotter_top #(
  parameter int SCREEN_COLS = tpz_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tpz_pkg::SCREEN_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // command stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tuser: func[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // tdata: cell_index[10:0] sin_phi[26:11] cos_phi[42:27]
  //        sin_tube[58:43] cos_tube[74:59], zero pad [79:75]
  input  logic [79:0] s_axis_tdata_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: cell_char[7:0] cell_depth[23:8] point_cell[34:24]
  //        shade_level[38:35] plotted[39]
  output logic [39:0] m_axis_tdata_o
);

  localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  tpz_pkg::ctl_cmd_t cmd;
  tpz_pkg::dp_stat_t stat;
  logic [ADDR_W-1:0] init_addr;

  // config regs live in the datapath, writes never stall
  assign cfg_ready_o = 1'b1;

  tpz_ctrl #(
    .CELLS(CELLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_func_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .init_addr_o (init_addr)
  );

  tpz_datapath #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i[74:0]),
    .cmd_i       (cmd),
    .init_addr_i (init_addr),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: rtl/core/tpz_ctrl.sv
// Sequencer of the plotter: sweeps, command dispatch and the plot step order.
module tpz_ctrl #(
  parameter int CELLS = tpz_pkg::SCREEN_COLS_DEF * tpz_pkg::SCREEN_ROWS_DEF,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_func_i,
  output logic                in_ready_o,
  input  tpz_pkg::dp_stat_t   stat_i,
  output tpz_pkg::ctl_cmd_t   cmd_o,
  output logic [ADDR_W-1:0]   init_addr_o
);

  tpz_pkg::state_e   state_q, state_d;
  tpz_pkg::mstep_e   step_q, step_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;

  assign init_addr_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpz_pkg::ST_INIT;
      step_q  <= tpz_pkg::MS_CPCT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      tpz_pkg::ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = tpz_pkg::ST_IDLE;
        end
      end
      tpz_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          unique case (tpz_pkg::func_e'(in_func_i))
            tpz_pkg::FUNC_CLEAR: state_d = tpz_pkg::ST_CLR;
            tpz_pkg::FUNC_PLOT: begin
              step_d  = tpz_pkg::MS_CPCT;
              state_d = tpz_pkg::ST_MUL;
            end
            tpz_pkg::FUNC_READ: state_d = tpz_pkg::ST_RD;
            default: begin
              cmd_o.zero_res = 1'b1;
              state_d = tpz_pkg::ST_FIN;
            end
          endcase
        end
      end
      tpz_pkg::ST_CLR: begin
        cmd_o.clr_cell = 1'b1;
        state_d = tpz_pkg::ST_FIN;
      end
      tpz_pkg::ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = tpz_pkg::ST_RDW;
      end
      tpz_pkg::ST_RDW: begin
        cmd_o.rd_take = 1'b1;
        state_d = tpz_pkg::ST_FIN;
      end
      tpz_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_q == tpz_pkg::MS_Y2) begin
          state_d = tpz_pkg::ST_DEN;
        end else begin
          step_d = tpz_pkg::mstep_e'(step_q + 5'd1);
        end
      end
      tpz_pkg::ST_DEN: begin
        cmd_o.den_en = 1'b1;
        state_d = tpz_pkg::ST_DCHK;
      end
      tpz_pkg::ST_DCHK: begin
        if (stat_i.den_pos) begin
          cmd_o.div_init = 1'b1;
          cnt_d   = '0;
          state_d = tpz_pkg::ST_DIV;
        end else begin
          cmd_o.miss = 1'b1;
          state_d = tpz_pkg::ST_FIN;
        end
      end
      tpz_pkg::ST_DIV: begin
        cmd_o.div_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(tpz_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = tpz_pkg::ST_MULX;
        end
      end
      tpz_pkg::ST_MULX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.step   = tpz_pkg::MS_XD;
        state_d = tpz_pkg::ST_MULY;
      end
      tpz_pkg::ST_MULY: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.step   = tpz_pkg::MS_YD;
        state_d = tpz_pkg::ST_PROJ;
      end
      tpz_pkg::ST_PROJ: begin
        cmd_o.proj_en = 1'b1;
        state_d = tpz_pkg::ST_CHK;
      end
      tpz_pkg::ST_CHK: begin
        cmd_o.chk_en = 1'b1;
        state_d = tpz_pkg::ST_LOOK;
      end
      tpz_pkg::ST_LOOK: begin
        if (stat_i.on_scr) begin
          cmd_o.look_rd = 1'b1;
          state_d = tpz_pkg::ST_CMP;
        end else begin
          cmd_o.miss = 1'b1;
          state_d = tpz_pkg::ST_FIN;
        end
      end
      tpz_pkg::ST_CMP: begin
        cmd_o.cmp_en = 1'b1;
        state_d = tpz_pkg::ST_FIN;
      end
      tpz_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = tpz_pkg::ST_IDLE;
        end
      end
      default: state_d = tpz_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/tpz_datapath.sv
// Plotter datapath: config registers, shared multiplier, divider, cell memories, result register.
module tpz_datapath #(
  parameter int SCREEN_COLS = tpz_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tpz_pkg::SCREEN_ROWS_DEF,
  localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [74:0]        in_data_i,
  input  tpz_pkg::ctl_cmd_t  cmd_i,
  input  logic [ADDR_W-1:0]  init_addr_i,
  output tpz_pkg::dp_stat_t  stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [39:0]        out_data_o
);

  localparam int MAX_X = (SCREEN_COLS * 3) / 8;
  localparam int MAX_Y = MAX_X / 2;
  localparam logic signed [49:0] MAX_X_S = 50'(MAX_X);
  localparam logic signed [49:0] MAX_Y_S = 50'(MAX_Y);

  // configuration
  logic signed [15:0] sa_q, ca_q, sb_q, cb_q;
  logic [14:0]        r1_q, r2_q;
  logic [15:0]        k2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      ca_q <= 16'sd16384;
      sb_q <= '0;
      cb_q <= 16'sd16384;
      r1_q <= 15'd41;
      r2_q <= 15'd8192;
      k2_q <= 16'd20480;
    end else if (cfg_we_i) begin
      unique case (tpz_pkg::cfg_idx_e'(cfg_index_i))
        tpz_pkg::CFG_SIN_A: sa_q <= $signed(cfg_data_i);
        tpz_pkg::CFG_COS_A: ca_q <= $signed(cfg_data_i);
        tpz_pkg::CFG_SIN_B: sb_q <= $signed(cfg_data_i);
        tpz_pkg::CFG_COS_B: cb_q <= $signed(cfg_data_i);
        tpz_pkg::CFG_R1:    r1_q <= cfg_data_i[14:0];
        tpz_pkg::CFG_R2:    r2_q <= cfg_data_i[14:0];
        tpz_pkg::CFG_K2:    k2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input item
  logic [10:0]        idx_q;
  logic signed [15:0] sp_q, cp_q, st_q, ct_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      idx_q <= in_data_i[10:0];
      sp_q  <= $signed(in_data_i[26:11]);
      cp_q  <= $signed(in_data_i[42:27]);
      st_q  <= $signed(in_data_i[58:43]);
      ct_q  <= $signed(in_data_i[74:59]);
    end
  end

  logic idx_ok;
  assign idx_ok = 32'(idx_q) < CELLS;

  // shared multiplier, Q1.14 products keep the other operand's format; the XD and YD products are kept unscaled
  logic signed [23:0] p1_q, n1_q, p2_q, n2_q, n3_q, p3_q, p4_q, n4_q;
  logic signed [23:0] q_q, hs_q, hc_q, z1_q, rsa_q, z2_q, t1_q, rst_q, t2_q;
  logic signed [23:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [41:0] xd_q, yd_q;
  logic signed [23:0] mul_a, h_v, t_v, r1_v;
  logic signed [17:0] mul_b, d_v;
  logic signed [41:0] prod;
  logic signed [23:0] tm;
  logic [15:0]        d_sat;

  assign r1_v = $signed({9'd0, r1_q});
  assign h_v  = $signed({9'd0, r2_q}) + q_q;
  assign t_v  = t1_q - t2_q;
  assign d_v  = $signed({2'b00, d_sat});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      tpz_pkg::MS_CPCT: begin mul_a = 24'(cp_q);  mul_b = 18'(ct_q); end
      tpz_pkg::MS_N1:   begin mul_a = p1_q;       mul_b = 18'(sb_q); end
      tpz_pkg::MS_CACT: begin mul_a = 24'(ca_q);  mul_b = 18'(ct_q); end
      tpz_pkg::MS_N2:   begin mul_a = p2_q;       mul_b = 18'(sp_q); end
      tpz_pkg::MS_N3:   begin mul_a = 24'(sa_q);  mul_b = 18'(st_q); end
      tpz_pkg::MS_CAST: begin mul_a = 24'(ca_q);  mul_b = 18'(st_q); end
      tpz_pkg::MS_CTSA: begin mul_a = 24'(ct_q);  mul_b = 18'(sa_q); end
      tpz_pkg::MS_P5:   begin mul_a = p4_q;       mul_b = 18'(sp_q); end
      tpz_pkg::MS_N4:   begin mul_a = p3_q - p4_q; mul_b = 18'(cb_q); end
      tpz_pkg::MS_Q:    begin mul_a = r1_v;       mul_b = 18'(ct_q); end
      tpz_pkg::MS_HS:   begin mul_a = h_v;        mul_b = 18'(sp_q); end
      tpz_pkg::MS_HC:   begin mul_a = h_v;        mul_b = 18'(cp_q); end
      tpz_pkg::MS_Z1:   begin mul_a = hs_q;       mul_b = 18'(ca_q); end
      tpz_pkg::MS_RSA:  begin mul_a = r1_v;       mul_b = 18'(sa_q); end
      tpz_pkg::MS_Z2:   begin mul_a = rsa_q;      mul_b = 18'(st_q); end
      tpz_pkg::MS_T1:   begin mul_a = hs_q;       mul_b = 18'(sa_q); end
      tpz_pkg::MS_RST:  begin mul_a = r1_v;       mul_b = 18'(st_q); end
      tpz_pkg::MS_T2:   begin mul_a = rst_q;      mul_b = 18'(ca_q); end
      tpz_pkg::MS_X1:   begin mul_a = hc_q;       mul_b = 18'(cb_q); end
      tpz_pkg::MS_X2:   begin mul_a = t_v;        mul_b = 18'(sb_q); end
      tpz_pkg::MS_Y1:   begin mul_a = hc_q;       mul_b = 18'(sb_q); end
      tpz_pkg::MS_Y2:   begin mul_a = t_v;        mul_b = 18'(cb_q); end
      tpz_pkg::MS_XD:   begin mul_a = x1_q + x2_q; mul_b = d_v; end
      tpz_pkg::MS_YD:   begin mul_a = y1_q - y2_q; mul_b = d_v; end
      default: ;
    endcase
  end

  assign prod = 42'(mul_a) * 42'(mul_b);
  assign tm   = prod[37:14];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.step)
        tpz_pkg::MS_CPCT: p1_q  <= tm;
        tpz_pkg::MS_N1:   n1_q  <= tm;
        tpz_pkg::MS_CACT: p2_q  <= tm;
        tpz_pkg::MS_N2:   n2_q  <= tm;
        tpz_pkg::MS_N3:   n3_q  <= tm;
        tpz_pkg::MS_CAST: p3_q  <= tm;
        tpz_pkg::MS_CTSA: p4_q  <= tm;
        tpz_pkg::MS_P5:   p4_q  <= tm;
        tpz_pkg::MS_N4:   n4_q  <= tm;
        tpz_pkg::MS_Q:    q_q   <= tm;
        tpz_pkg::MS_HS:   hs_q  <= tm;
        tpz_pkg::MS_HC:   hc_q  <= tm;
        tpz_pkg::MS_Z1:   z1_q  <= tm;
        tpz_pkg::MS_RSA:  rsa_q <= tm;
        tpz_pkg::MS_Z2:   z2_q  <= tm;
        tpz_pkg::MS_T1:   t1_q  <= tm;
        tpz_pkg::MS_RST:  rst_q <= tm;
        tpz_pkg::MS_T2:   t2_q  <= tm;
        tpz_pkg::MS_X1:   x1_q  <= tm;
        tpz_pkg::MS_X2:   x2_q  <= tm;
        tpz_pkg::MS_Y1:   y1_q  <= tm;
        tpz_pkg::MS_Y2:   y2_q  <= tm;
        tpz_pkg::MS_XD:   xd_q  <= prod;
        tpz_pkg::MS_YD:   yd_q  <= prod;
        default: ;
      endcase
    end
  end

  // shade: level = trunc(8.4 * N), by threshold compare, clipped at 11
  logic signed [25:0] n_v;
  logic signed [31:0] n42;
  logic [3:0]         lvl;

  assign n_v = 26'(n1_q) - 26'(n2_q) - 26'(n3_q) + 26'(n4_q);
  assign n42 = 32'(n_v) * 32'sd42;

  always_comb begin
    lvl = '0;
    for (int k = 1; k <= 11; k++) begin
      if (n_v > 0 && n42 >= 32'(81920 * k)) lvl = 4'(k);
    end
  end

  // denominator and restoring divider for 2^28 / den
  logic signed [24:0] den_q;
  logic [23:0]        rem_q;
  logic [28:0]        dvd_q, quo_q;
  logic [24:0]        rem_sh;
  logic               fits;

  assign rem_sh = {rem_q, dvd_q[28]};
  assign fits   = rem_sh >= {1'b0, den_q[23:0]};
  assign d_sat  = (quo_q > 29'd65535) ? 16'hFFFF : quo_q[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.den_en) begin
      den_q <= $signed({9'd0, k2_q}) + 25'(z1_q) + 25'(z2_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= 29'h1000_0000;
    end else if (cmd_i.div_en) begin
      rem_q <= fits ? 24'(rem_sh - {1'b0, den_q[23:0]}) : rem_sh[23:0];
      quo_q <= {quo_q[27:0], fits};
      dvd_q <= {dvd_q[27:0], 1'b0};
    end
  end

  // projection to a text cell
  logic signed [49:0] mx_q, my_q;
  logic signed [22:0] col_v, row_v;
  logic               on_scr_q;
  logic [ADDR_W-1:0]  pos_q;

  assign col_v = 23'($signed(mx_q[49:28])) + 23'(SCREEN_COLS / 2);
  assign row_v = 23'($signed(my_q[49:28])) + 23'(SCREEN_ROWS / 2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.proj_en) begin
      mx_q <= 50'(xd_q) * MAX_X_S;
      my_q <= 50'(yd_q) * MAX_Y_S;
    end
    if (cmd_i.chk_en) begin
      on_scr_q <= col_v > 0 && col_v < 23'(SCREEN_COLS) &&
                  row_v > 0 && row_v < 23'(SCREEN_ROWS);
      pos_q    <= ADDR_W'(col_v) + ADDR_W'(row_v * 23'(SCREEN_COLS));
    end
  end

  // pending result and output register
  logic [7:0]  pnd_char_q;
  logic [15:0] pnd_depth_q;
  logic [10:0] pnd_cell_q;
  logic [3:0]  pnd_shade_q;
  logic        pnd_plot_q;
  logic        out_valid_q;
  logic [39:0] out_data_q;

  // cell memories, one write and one registered read a cycle
  logic [15:0]       depth_mem [CELLS];
  logic [7:0]        char_mem  [CELLS];
  logic [15:0]       rd_depth_q;
  logic [7:0]        rd_char_q;
  logic              win;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdepth;
  logic [7:0]        wchar;

  assign win = {16'd0, d_sat} > {16'd0, rd_depth_q};

  always_comb begin
    mem_we = 1'b0;
    waddr  = init_addr_i;
    wdepth = '0;
    wchar  = tpz_pkg::CHAR_SPACE;
    if (cmd_i.init_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.clr_cell) begin
      mem_we = idx_ok;
      waddr  = ADDR_W'(idx_q);
    end else if (cmd_i.cmp_en) begin
      mem_we = win;
      waddr  = pos_q;
      wdepth = d_sat;
      wchar  = tpz_pkg::shade_char(pnd_shade_q);
    end
  end

  assign mem_re = cmd_i.rd_issue | cmd_i.look_rd;
  assign raddr  = cmd_i.look_rd ? pos_q : ADDR_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      depth_mem[waddr] <= wdepth;
      char_mem[waddr]  <= wchar;
    end
    if (mem_re) begin
      rd_depth_q <= depth_mem[raddr];
      rd_char_q  <= char_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.zero_res) begin
      pnd_char_q  <= '0;
      pnd_depth_q <= '0;
      pnd_cell_q  <= '0;
      pnd_shade_q <= '0;
      pnd_plot_q  <= 1'b0;
    end
    if (cmd_i.clr_cell) begin
      pnd_char_q  <= idx_ok ? tpz_pkg::CHAR_SPACE : 8'd0;
      pnd_depth_q <= '0;
      pnd_cell_q  <= '0;
      pnd_shade_q <= '0;
      pnd_plot_q  <= 1'b0;
    end
    if (cmd_i.rd_take) begin
      pnd_char_q  <= idx_ok ? rd_char_q : 8'd0;
      pnd_depth_q <= idx_ok ? rd_depth_q : 16'd0;
      pnd_cell_q  <= '0;
      pnd_shade_q <= '0;
      pnd_plot_q  <= 1'b0;
    end
    if (cmd_i.den_en) begin
      pnd_shade_q <= lvl;
    end
    if (cmd_i.miss) begin
      pnd_char_q  <= '0;
      pnd_depth_q <= '0;
      pnd_cell_q  <= '0;
      pnd_plot_q  <= 1'b0;
    end
    if (cmd_i.cmp_en) begin
      pnd_char_q  <= win ? tpz_pkg::shade_char(pnd_shade_q) : rd_char_q;
      pnd_depth_q <= win ? d_sat : rd_depth_q;
      pnd_cell_q  <= 11'(pos_q);
      pnd_plot_q  <= win;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {pnd_plot_q, pnd_shade_q, pnd_cell_q, pnd_depth_q, pnd_char_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign stat_o.idx_ok   = idx_ok;
  assign stat_o.den_pos  = den_q > 0;
  assign stat_o.on_scr   = on_scr_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule
